### hdl/arp_rr_pkg.sv
`timescale 1ns / 1ps

package arp_rr_pkg;

  // Register indexes on the configuration port
  localparam logic CFG_STATION_MAC = 1'b0;
  localparam logic CFG_STATION_IP  = 1'b1;

  localparam int CFG_DATA_W = 48;

  localparam int REPLY_LENGTH_DEF = 60;
  localparam int REPLY_IDX_W      = 7;

  // Frame layout and field values
  localparam int          POS_W           = 6;
  localparam logic [5:0]  POS_MAX         = 6'd63;
  localparam logic [5:0]  POS_SRC_MAC_LO  = 6'd6;
  localparam logic [5:0]  POS_SRC_MAC_HI  = 6'd11;
  localparam logic [5:0]  POS_TYPE_LO     = 6'd12;
  localparam logic [5:0]  POS_TYPE_HI     = 6'd13;
  localparam logic [5:0]  POS_SRC_IP_LO   = 6'd28;
  localparam logic [5:0]  POS_SRC_IP_HI   = 6'd31;
  localparam int          MIN_FRAME       = 42;
  localparam logic [5:0]  POS_MIN_LAST    = 6'(MIN_FRAME - 1);

  localparam logic [15:0] ETHERTYPE_ARP   = 16'h0806;
  localparam logic [15:0] ARP_HTYPE_ETH   = 16'h0001;
  localparam logic [15:0] ARP_PTYPE_IPV4  = 16'h0800;
  localparam logic [7:0]  ARP_HLEN        = 8'h06;
  localparam logic [7:0]  ARP_PLEN        = 8'h04;
  localparam logic [15:0] ARP_OPER_REPLY  = 16'h0002;

  localparam logic [47:0] STATION_MAC_RST = 48'h080000270013;
  localparam logic [31:0] STATION_IP_RST  = 32'hC0A83842;

  // Peer addresses captured for one reply
  typedef struct packed {
    logic        valid;
    logic [47:0] peer_mac;
    logic [31:0] peer_ip;
  } reply_req_t;

  // Byte idx of the reply frame; everything past the ARP body is padding
  function automatic logic [7:0] reply_byte_at(
    input logic [REPLY_IDX_W-1:0] idx,
    input logic [47:0]            peer_mac,
    input logic [31:0]            peer_ip,
    input logic [47:0]            station_mac,
    input logic [31:0]            station_ip
  );
    logic [MIN_FRAME*8-1:0] hdr;
    logic [MIN_FRAME*8-1:0] shifted;
    logic [7:0]             res;
    hdr = {peer_mac, station_mac, ETHERTYPE_ARP, ARP_HTYPE_ETH, ARP_PTYPE_IPV4,
           ARP_HLEN, ARP_PLEN, ARP_OPER_REPLY, station_mac, station_ip,
           peer_mac, peer_ip};
    shifted = hdr << (8 * int'(idx));
    if (int'(idx) < MIN_FRAME) begin
      res = shifted[MIN_FRAME*8-1 -: 8];
    end else begin
      res = 8'h00;
    end
    return res;
  endfunction

endpackage

### hdl/arp_rr_cfg_regs.sv
`timescale 1ns / 1ps

module arp_rr_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [arp_rr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic [47:0]                        station_mac,
  output logic [31:0]                        station_ip
);
  import arp_rr_pkg::*;

  logic [47:0] station_mac_r;
  logic [31:0] station_ip_r;

  assign cfg_ready   = 1'b1;
  assign station_mac = station_mac_r;
  assign station_ip  = station_ip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_mac_r <= STATION_MAC_RST;
      station_ip_r  <= STATION_IP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_STATION_MAC: station_mac_r <= cfg_data;
        CFG_STATION_IP:  station_ip_r  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

endmodule

### hdl/arp_rr_rx_parse.sv
`timescale 1ns / 1ps

module arp_rr_rx_parse (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,
  input  logic                   in_tlast,
  output arp_rr_pkg::reply_req_t req,
  input  logic                   req_take
);
  import arp_rr_pkg::*;

  logic [POS_W-1:0] pos_r;
  logic [15:0]      frame_type_r;
  logic [47:0]      peer_mac_r;
  logic [31:0]      peer_ip_r;
  reply_req_t       pend_r;
  logic             accept;
  logic             trigger;

  // One reply may wait here while the generator is busy with another
  assign in_tready = !pend_r.valid || req_take;
  assign accept    = in_tvalid && in_tready;
  assign req       = pend_r;

  // Fields are final by the time a long enough frame ends
  assign trigger = accept && in_tlast && (pos_r >= POS_MIN_LAST) &&
                   (frame_type_r == ETHERTYPE_ARP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      frame_type_r <= '0;
      peer_mac_r   <= '0;
      peer_ip_r    <= '0;
    end else if (accept) begin
      if (pos_r >= POS_SRC_MAC_LO && pos_r <= POS_SRC_MAC_HI) begin
        peer_mac_r <= {peer_mac_r[39:0], in_tdata};
      end else if (pos_r == POS_TYPE_LO || pos_r == POS_TYPE_HI) begin
        frame_type_r <= {frame_type_r[7:0], in_tdata};
      end else if (pos_r >= POS_SRC_IP_LO && pos_r <= POS_SRC_IP_HI) begin
        peer_ip_r <= {peer_ip_r[23:0], in_tdata};
      end
      if (in_tlast) begin
        pos_r <= '0;
      end else if (pos_r != POS_MAX) begin
        pos_r <= pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (trigger) begin
      pend_r.peer_mac <= peer_mac_r;
      pend_r.peer_ip  <= peer_ip_r;
    end
    if (!rst_n) begin
      pend_r.valid <= 1'b0;
    end else if (trigger) begin
      pend_r.valid <= 1'b1;
    end else if (req_take) begin
      pend_r.valid <= 1'b0;
    end
  end

endmodule

### hdl/arp_rr_tx_gen.sv
`timescale 1ns / 1ps

module arp_rr_tx_gen #(
  parameter int REPLY_LENGTH = arp_rr_pkg::REPLY_LENGTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  arp_rr_pkg::reply_req_t req,
  output logic                   req_take,
  input  logic [47:0]            station_mac,
  input  logic [31:0]            station_ip,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [7:0]             out_tdata,
  output logic                   out_tlast
);
  import arp_rr_pkg::*;

  localparam int              IDX_W    = $clog2(REPLY_LENGTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REPLY_LENGTH - 1);

  logic             active_r;
  logic [IDX_W-1:0] idx_r;
  logic [47:0]      peer_mac_r;
  logic [31:0]      peer_ip_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;
  logic             advance;
  logic             at_last;
  logic [7:0]       byte_nxt;

  assign advance  = active_r && (!out_valid_r || out_tready);
  assign at_last  = (idx_r == LAST_IDX);
  assign req_take = req.valid && (!active_r || (advance && at_last));
  assign byte_nxt = reply_byte_at(REPLY_IDX_W'(idx_r), peer_mac_r, peer_ip_r,
                                  station_mac, station_ip);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
    end else if (req_take) begin
      active_r <= 1'b1;
      idx_r    <= '0;
    end else if (advance) begin
      if (at_last) begin
        active_r <= 1'b0;
      end
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      peer_mac_r <= req.peer_mac;
      peer_ip_r  <= req.peer_ip;
    end
  end

  // Output register: load a byte whenever the slot is free or being drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r <= byte_nxt;
      out_last_r <= at_last;
    end
  end

endmodule

### hdl/arp_reply_responder_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// in_       receive    in_tvalid/in_tready  tdata: rx_byte[7:0]; tlast: frame_end
// out_      send       out_tvalid/out_tready tdata: reply_byte[7:0]; tlast: reply_last
// cfg_      receive    cfg_valid/cfg_ready  cfg_index (0 station_mac, 1 station_ip), cfg_data
//
// One received byte per cycle while in_tready is high; the parser updates its fields
// in the accept cycle. A qualifying frame end queues a reply; REPLY_LENGTH bytes leave
// from the output register at one per cycle while out_tready is high.
// One further reply can wait while another is sent; in_tready stays low while such a
// reply waits, until the generator takes it. rst_n is synchronous; the station
// registers reset to their default addresses, all other control state to zero.

module arp_reply_responder_unit #(
  parameter int REPLY_LENGTH = arp_rr_pkg::REPLY_LENGTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] rx_byte
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,  // [7:0] reply_byte
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [arp_rr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import arp_rr_pkg::*;

  logic [47:0] station_mac;
  logic [31:0] station_ip;
  reply_req_t  req;
  logic        req_take;

  arp_rr_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .station_mac (station_mac),
    .station_ip  (station_ip)
  );

  arp_rr_rx_parse u_rx (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .req       (req),
    .req_take  (req_take)
  );

  arp_rr_tx_gen #(
    .REPLY_LENGTH (REPLY_LENGTH)
  ) u_tx (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req),
    .req_take    (req_take),
    .station_mac (station_mac),
    .station_ip  (station_ip),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule
